@@ rtl/dkd_pkg.sv @@
// Shared types and constants for the two-key debouncer with combo hold.
// No dependencies.
`default_nettype none

package dkd_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [15:0] HOLD_RESET = 16'd2000;

  localparam int REG_COUNT = 2;
  localparam int ADDR_WIDTH = 3;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_PRESS_DB   = 2'd1,
    PH_PRESSED    = 2'd2,
    PH_RELEASE_DB = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_CONFIRM = 2'd0,
    EV_BACK    = 2'd1,
    EV_RESET   = 2'd2
  } event_t;

  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_HOLD     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic pressed;
    logic pressed_next;
    logic hit;
  } lane_status_t;

endpackage

`default_nettype wire

@@ rtl/dkd_lane.sv @@
// One key's four-phase debouncer lane.
// Depends on dkd_pkg.
`default_nettype none

module dkd_lane #(
  parameter int TIME_WIDTH = dkd_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [TIME_WIDTH-1:0] now,
  input  wire logic                  level,
  input  wire logic [15:0]           debounce_ms,
  output dkd_pkg::lane_status_t      status
);

  dkd_pkg::phase_t phase, phase_next;
  logic prev_level, prev_level_next;
  logic [TIME_WIDTH-1:0] mark, mark_next;
  logic [TIME_WIDTH-1:0] elapsed;
  logic settled;
  logic hit;

  assign elapsed = now - mark;
  assign settled = elapsed >= TIME_WIDTH'(debounce_ms);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      dkd_pkg::PH_IDLE: begin
        if (!level && prev_level) phase_next = dkd_pkg::PH_PRESS_DB;
      end
      dkd_pkg::PH_PRESS_DB: begin
        if (settled) phase_next = level ? dkd_pkg::PH_IDLE : dkd_pkg::PH_PRESSED;
      end
      dkd_pkg::PH_PRESSED: begin
        if (level && !prev_level) phase_next = dkd_pkg::PH_RELEASE_DB;
      end
      dkd_pkg::PH_RELEASE_DB: begin
        if (settled) phase_next = dkd_pkg::PH_IDLE;
      end
      default: phase_next = dkd_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    mark_next = mark;
    prev_level_next = level;
    hit = 1'b0;
    unique case (phase)
      dkd_pkg::PH_IDLE: begin
        if (!level && prev_level) mark_next = now;
      end
      dkd_pkg::PH_PRESS_DB: begin
        if (settled && !level) begin
          hit = 1'b1;
          prev_level_next = prev_level;
        end
      end
      dkd_pkg::PH_PRESSED: begin
        if (level && !prev_level) mark_next = now;
      end
      dkd_pkg::PH_RELEASE_DB: begin
        mark_next = mark;
      end
      default: mark_next = mark;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= dkd_pkg::PH_IDLE;
      prev_level <= 1'b1;
      mark <= '0;
    end else if (accept) begin
      phase <= phase_next;
      prev_level <= prev_level_next;
      mark <= mark_next;
    end
  end

  assign status.pressed = (phase == dkd_pkg::PH_PRESSED);
  assign status.pressed_next = (phase_next == dkd_pkg::PH_PRESSED);
  assign status.hit = hit;

endmodule

`default_nettype wire

@@ rtl/dkd_merge.sv @@
// Merge stage: combo hold timer, event priority and two-entry output buffer.
// Depends on dkd_pkg.
`default_nettype none

module dkd_merge #(
  parameter int TIME_WIDTH = dkd_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [TIME_WIDTH-1:0] now,
  input  wire logic [15:0]           hold_ms,
  input  wire dkd_pkg::lane_status_t confirm_st,
  input  wire dkd_pkg::lane_status_t back_st,
  output logic                       room,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output dkd_pkg::event_t            out_event
);

  logic both;
  logic fire;
  logic have;
  dkd_pkg::event_t ev;
  logic combo_running;
  logic [TIME_WIDTH-1:0] combo_start;
  logic push, pop;
  logic head_valid, skid_valid;
  dkd_pkg::event_t head, skid;

  assign both = confirm_st.pressed_next && back_st.pressed_next;
  assign fire = both && combo_running && ((now - combo_start) > TIME_WIDTH'(hold_ms));
  assign have = fire || confirm_st.hit || back_st.hit;

  always_comb begin
    priority if (fire) ev = dkd_pkg::EV_RESET;
    else if (back_st.hit) ev = dkd_pkg::EV_BACK;
    else ev = dkd_pkg::EV_CONFIRM;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      combo_running <= 1'b0;
      combo_start <= '0;
    end else if (accept) begin
      if (!both || fire) begin
        combo_running <= 1'b0;
      end else if (!combo_running) begin
        combo_running <= 1'b1;
        combo_start <= now;
      end
    end
  end

  // head drives the port, skid catches a request while head is stalled
  assign push = accept && have;
  assign pop = head_valid && out_ready;
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head <= skid;
        skid_valid <= 1'b0;
      end else if (push) begin
        head <= ev;
      end else begin
        head_valid <= 1'b0;
      end
    end else if (push) begin
      if (!head_valid) begin
        head <= ev;
        head_valid <= 1'b1;
      end else begin
        skid <= ev;
        skid_valid <= 1'b1;
      end
    end
  end

  assign out_valid = head_valid;
  assign out_event = head;

`ifndef SYNTHESIS
  a_skid_needs_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid) else $error("skid holds a request with head empty");

  a_combo_both_pressed: assert property (@(posedge clk) disable iff (rst)
    combo_running |-> (confirm_st.pressed && back_st.pressed))
    else $error("combo timer running without both keys pressed");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(head_valid && !out_ready))
    else $error("skid filled while head was free");
`endif

endmodule

`default_nettype wire

@@ rtl/dual_key_debounce_with_combo_hold.sv @@
// Top level: two debouncer lanes, merge stage and APB register block.
// Depends on dkd_pkg, dkd_lane and dkd_merge.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  in       | in_valid / in_ready    | now_ms, confirm_level, back_level
//  out      | out_valid / out_ready  | key_event
//  apb      | psel, penable, pready  | paddr, pwrite, pwdata, prdata
//
// One scan per cycle while in_ready is high; both lanes update in the cycle
// a scan is accepted. Results are registered in a two-entry buffer.
// in_ready drops only when both buffer entries are held by a stalled output.
// Synchronous reset; no clearing pass, ready the cycle after reset.
`default_nettype none

module dual_key_debounce_with_combo_hold #(
  parameter int TIME_WIDTH = dkd_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [31:0]                    now_ms,
  input  wire logic                           confirm_level,
  input  wire logic                           back_level,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          key_event,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dkd_pkg::ADDR_WIDTH-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [15:0] debounce_ms;
  logic [15:0] hold_ms;
  logic accept;
  logic room;
  logic [TIME_WIDTH-1:0] now;
  dkd_pkg::lane_status_t confirm_st, back_st;
  dkd_pkg::event_t out_event;
  dkd_pkg::reg_idx_t reg_sel;

  assign pready = 1'b1;
  assign reg_sel = dkd_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= dkd_pkg::DEBOUNCE_RESET;
      hold_ms <= dkd_pkg::HOLD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        dkd_pkg::REG_DEBOUNCE: debounce_ms <= pwdata[15:0];
        dkd_pkg::REG_HOLD:     hold_ms <= pwdata[15:0];
        default:               debounce_ms <= debounce_ms;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dkd_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_ms};
      dkd_pkg::REG_HOLD:     prdata = {16'd0, hold_ms};
      default:               prdata = '0;
    endcase
  end

  assign now = TIME_WIDTH'(now_ms);
  assign in_ready = room;
  assign accept = in_valid && in_ready;

  dkd_lane #(.TIME_WIDTH(TIME_WIDTH)) u_confirm (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .now         (now),
    .level       (confirm_level),
    .debounce_ms (debounce_ms),
    .status      (confirm_st)
  );

  dkd_lane #(.TIME_WIDTH(TIME_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .now         (now),
    .level       (back_level),
    .debounce_ms (debounce_ms),
    .status      (back_st)
  );

  dkd_merge #(.TIME_WIDTH(TIME_WIDTH)) u_merge (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .now        (now),
    .hold_ms    (hold_ms),
    .confirm_st (confirm_st),
    .back_st    (back_st),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_event  (out_event)
  );

  assign key_event = out_event;

endmodule

`default_nettype wire
